FILE: rtl/core/aeawb_pkg.sv
// ----------------------------------------------------------------------------
// aeawb_pkg
// Shared types and constants for the auto exposure and white balance block.
// ----------------------------------------------------------------------------
package aeawb_pkg;

  localparam int unsigned ACC_W   = 48;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 16;

  localparam logic [CFG_A_W-1:0] CFG_LUMA_TARGET   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_LUMA_DEADBAND = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_EXP_FLOOR     = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_EXP_CEILING   = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_FLOOR    = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_CEILING  = 3'd5;
  localparam logic [CFG_A_W-1:0] CFG_RED_SCALE     = 3'd6;
  localparam logic [CFG_A_W-1:0] CFG_BLUE_SCALE    = 3'd7;

  localparam logic [15:0] RST_LUMA_TARGET   = 16'd1419;
  localparam logic [15:0] RST_LUMA_DEADBAND = 16'd15;
  localparam logic [15:0] RST_EXP_FLOOR     = 16'd4;
  localparam logic [15:0] RST_EXP_CEILING   = 16'd3522;
  localparam logic [7:0]  RST_GAIN_FLOOR    = 8'd0;
  localparam logic [7:0]  RST_GAIN_CEILING  = 8'd232;
  localparam logic [11:0] RST_RED_SCALE     = 12'd1100;
  localparam logic [11:0] RST_BLUE_SCALE    = 12'd950;

  localparam logic [15:0] RST_EXPOSURE  = 16'd1600;
  localparam logic [7:0]  RST_GAIN      = 8'd0;
  localparam logic [15:0] RST_WB_GAIN   = 16'd1000;

  // Frame snapshot queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Shared restoring divider.
  localparam int unsigned DIV_DVD_W = 60;
  localparam int unsigned DIV_DSR_W = 48;
  localparam int unsigned DIV_Q_W   = 20;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd59;

  // floor(x / 10) = (x * RECIP10) >> 26, exact for x below 2^20.
  localparam logic [22:0] RECIP10 = 23'd6710887;

  typedef struct packed {
    logic [15:0] luma_target;
    logic [15:0] luma_deadband;
    logic [15:0] exposure_floor;
    logic [15:0] exposure_ceiling;
    logic [7:0]  gain_floor;
    logic [7:0]  gain_ceiling;
    logic [11:0] red_target_scale;
    logic [11:0] blue_target_scale;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] light;
    logic [TOT_W-1:0] exp_total;
    logic [ACC_W-1:0] red;
    logic [ACC_W-1:0] green;
    logic [ACC_W-1:0] blue;
    logic             bal_ok;
  } frame_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
    logic               overflow;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LUMA_DIV,
    BK_AE_MUL,
    BK_AE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_BAL_DIV,
    BK_BAL_MUL,
    BK_BAL_STEP,
    BK_OUT
  } bk_state_e;

  function automatic logic [16:0] div10(input logic [19:0] x);
    logic [42:0] p;
    p = 43'(x) * 43'(RECIP10);
    return p[42:26];
  endfunction

endpackage

FILE: rtl/core/aeawb_front.sv
// ----------------------------------------------------------------------------
// aeawb_front
// Accumulates region statistics and hands a frame snapshot on at frame end.
// ----------------------------------------------------------------------------
module aeawb_front #(
  parameter int unsigned EXPOSURE_REGIONS = 16,
  parameter int unsigned BALANCE_REGIONS  = 192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          mode_i,
  input  logic [aeawb_pkg::SUM_W-1:0]   red_sum_i,
  input  logic [aeawb_pkg::SUM_W-1:0]   green_sum_i,
  input  logic [aeawb_pkg::SUM_W-1:0]   blue_sum_i,
  input  logic [aeawb_pkg::CNT_W-1:0]   pixel_count_i,
  input  logic                          frame_end_i,
  output logic                          snap_push_o,
  output aeawb_pkg::frame_t             snap_o
);

  localparam int unsigned EXP_CW = $clog2(EXPOSURE_REGIONS + 1);
  localparam int unsigned BAL_CW = $clog2(BALANCE_REGIONS + 1);
  localparam int unsigned A      = aeawb_pkg::ACC_W;
  localparam int unsigned T      = aeawb_pkg::TOT_W;

  logic [A-1:0]      light_q, light_d, red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [T-1:0]      etot_q, etot_d, btot_q, btot_d;
  logic [EXP_CW-1:0] exp_seen_q, exp_seen_d;
  logic [BAL_CW-1:0] bal_seen_q, bal_seen_d;

  logic [A+1:0] light_sum;
  logic [A:0]   red_sum, green_sum, blue_sum;
  logic [T:0]   etot_sum, btot_sum;
  logic         take_exp, take_bal;

  assign light_sum = (A+2)'(light_q) + (A+2)'(red_sum_i) + (A+2)'(green_sum_i)
                   + (A+2)'(blue_sum_i);
  assign red_sum   = (A+1)'(red_q) + (A+1)'(red_sum_i);
  assign green_sum = (A+1)'(green_q) + (A+1)'(green_sum_i);
  assign blue_sum  = (A+1)'(blue_q) + (A+1)'(blue_sum_i);
  assign etot_sum  = (T+1)'(etot_q) + (T+1)'(pixel_count_i);
  assign btot_sum  = (T+1)'(btot_q) + (T+1)'(pixel_count_i);

  assign take_exp = accept_i && !mode_i && (exp_seen_q < EXP_CW'(EXPOSURE_REGIONS));
  assign take_bal = accept_i && mode_i && (bal_seen_q < BAL_CW'(BALANCE_REGIONS));

  always_comb begin
    light_d    = light_q;
    etot_d     = etot_q;
    red_d      = red_q;
    green_d    = green_q;
    blue_d     = blue_q;
    btot_d     = btot_q;
    exp_seen_d = exp_seen_q;
    bal_seen_d = bal_seen_q;
    if (take_exp) begin
      exp_seen_d = exp_seen_q + EXP_CW'(1);
      light_d    = (|light_sum[A+1:A]) ? '1 : light_sum[A-1:0];
      etot_d     = etot_sum[T] ? '1 : etot_sum[T-1:0];
    end
    if (take_bal) begin
      bal_seen_d = bal_seen_q + BAL_CW'(1);
      red_d      = red_sum[A] ? '1 : red_sum[A-1:0];
      green_d    = green_sum[A] ? '1 : green_sum[A-1:0];
      blue_d     = blue_sum[A] ? '1 : blue_sum[A-1:0];
      btot_d     = btot_sum[T] ? '1 : btot_sum[T-1:0];
    end
  end

  assign snap_push_o      = accept_i && frame_end_i;
  assign snap_o.light     = light_d;
  assign snap_o.exp_total = etot_d;
  assign snap_o.red       = red_d;
  assign snap_o.green     = green_d;
  assign snap_o.blue      = blue_d;
  assign snap_o.bal_ok    = (|btot_d) && (|red_d) && (|green_d) && (|blue_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q    <= '0;
      etot_q     <= '0;
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
      btot_q     <= '0;
      exp_seen_q <= '0;
      bal_seen_q <= '0;
    end else if (snap_push_o) begin
      light_q    <= '0;
      etot_q     <= '0;
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
      btot_q     <= '0;
      exp_seen_q <= '0;
      bal_seen_q <= '0;
    end else begin
      light_q    <= light_d;
      etot_q     <= etot_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
      btot_q     <= btot_d;
      exp_seen_q <= exp_seen_d;
      bal_seen_q <= bal_seen_d;
    end
  end

endmodule

FILE: rtl/core/aeawb_queue.sv
// ----------------------------------------------------------------------------
// aeawb_queue
// Short queue of frame snapshots between the front and the back.
// ----------------------------------------------------------------------------
module aeawb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aeawb_pkg::frame_t wdata_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output aeawb_pkg::frame_t head_o
);

  aeawb_pkg::frame_t                 mem_q [aeawb_pkg::QUEUE_DEPTH];
  logic [aeawb_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
  logic [aeawb_pkg::QCNT_W-1:0]      count_q;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == aeawb_pkg::QCNT_W'(aeawb_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + aeawb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + aeawb_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + aeawb_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - aeawb_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/aeawb_div.sv
// ----------------------------------------------------------------------------
// aeawb_div
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
// ----------------------------------------------------------------------------
module aeawb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aeawb_pkg::div_req_t req_i,
  output aeawb_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = aeawb_pkg::DIV_DVD_W;
  localparam int unsigned SW = aeawb_pkg::DIV_DSR_W;
  localparam int unsigned QW = aeawb_pkg::DIV_Q_W;

  logic [DW-1:0]                   dvd_q;
  logic [SW-1:0]                   dsr_q, rem_q;
  logic [QW-1:0]                   quo_q;
  logic                            ovf_q, busy_q, done_q;
  logic [aeawb_pkg::DIV_CNT_W-1:0] cnt_q;

  logic [SW:0]   trial;
  logic [SW+1:0] diff;
  logic          qbit;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = (SW+2)'(trial) - (SW+2)'(dsr_q);
  assign qbit  = !diff[SW+1];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.overflow = ovf_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= qbit ? diff[SW-1:0] : trial[SW-1:0];
      quo_q <= {quo_q[QW-2:0], qbit};
      ovf_q <= ovf_q | quo_q[QW-1];
      cnt_q <= cnt_q + aeawb_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == aeawb_pkg::DIV_LAST) && !req_i.start;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == aeawb_pkg::DIV_LAST)) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/aeawb_back.sv
// ----------------------------------------------------------------------------
// aeawb_back
// Frame evaluation sequencer: luma, exposure and gain step, gray-world gains.
// ----------------------------------------------------------------------------
module aeawb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aeawb_pkg::cfg_t     cfg_i,
  input  logic                head_valid_i,
  input  aeawb_pkg::frame_t   head_i,
  output logic                head_pop_o,
  output aeawb_pkg::div_req_t div_req_o,
  input  aeawb_pkg::div_rsp_t div_rsp_i,
  input  logic                out_pop_i,
  output logic                out_empty_o,
  output logic [15:0]         exposure_o,
  output logic [7:0]          analog_gain_o,
  output logic [15:0]         red_wb_o,
  output logic [15:0]         blue_wb_o,
  output logic [15:0]         luma_o,
  output logic signed [16:0]  luma_error_o,
  output logic                exposure_updated_o,
  output logic                balance_updated_o,
  output logic                frame_skipped_o
);

  aeawb_pkg::bk_state_e state_q, state_d;

  logic [15:0]        exposure_q, exposure_d, rgain_q, rgain_d, bgain_q, bgain_d;
  logic [7:0]         gain_q, gain_d;
  logic [15:0]        luma_q, luma_d;
  logic signed [16:0] err_q, err_d;
  logic               exp_upd_q, exp_upd_d, bal_upd_q, bal_upd_d, skip_q, skip_d;
  logic               sel_blue_q, sel_blue_d, up_q, up_d;
  logic [11:0]        mag20_q, mag20_d;
  logic [16:0]        d10_q, d10_d;
  logic [35:0]        plo_q, plo_d;
  logic               out_valid_q, out_load;

  logic [11:0]        scale;
  logic [47:0]        csum;
  logic [35:0]        mul_lo, mul_hi;
  logic [59:0]        product;
  logic [15:0]        luma_sat;
  logic [15:0]        mag;
  logic [14:0]        mag2;
  logic [19:0]        tgt, dlt;
  logic [15:0]        cur_gain;
  logic               tgt_up;
  logic [16:0]        e_up;
  logic signed [17:0] e_dn;
  logic [12:0]        g_up;
  logic signed [12:0] g_dn;
  logic [17:0]        b_up;

  assign scale    = sel_blue_q ? cfg_i.blue_target_scale : cfg_i.red_target_scale;
  assign csum     = sel_blue_q ? head_i.blue : head_i.red;
  assign mul_lo   = 36'(scale) * 36'(head_i.green[23:0]);
  assign mul_hi   = 36'(scale) * 36'(head_i.green[47:24]);
  assign product  = 60'(plo_q) + {mul_hi, 24'b0};

  assign luma_sat = (div_rsp_i.overflow || (|div_rsp_i.quotient[19:16])) ?
                    16'hFFFF : div_rsp_i.quotient[15:0];
  assign mag      = err_q[16] ? 16'(17'sd0 - err_q) : err_q[15:0];
  assign mag2     = mag[15:1];

  assign tgt      = div_rsp_i.overflow ? '1 : div_rsp_i.quotient;
  assign cur_gain = sel_blue_q ? bgain_q : rgain_q;
  assign tgt_up   = tgt >= 20'(cur_gain);
  assign dlt      = tgt_up ? (tgt - 20'(cur_gain)) : (20'(cur_gain) - tgt);

  assign e_up = 17'(exposure_q) + 17'(mag2);
  assign e_dn = $signed(18'(exposure_q)) - $signed(18'(mag2));
  assign g_up = 13'(gain_q) + 13'(mag20_q);
  assign g_dn = $signed(13'(gain_q)) - $signed(13'(mag20_q));
  assign b_up = 18'(cur_gain) + 18'(d10_q);

  always_comb begin
    state_d    = state_q;
    exposure_d = exposure_q;
    gain_d     = gain_q;
    rgain_d    = rgain_q;
    bgain_d    = bgain_q;
    luma_d     = luma_q;
    err_d      = err_q;
    exp_upd_d  = exp_upd_q;
    bal_upd_d  = bal_upd_q;
    skip_d     = skip_q;
    sel_blue_d = sel_blue_q;
    up_d       = up_q;
    mag20_d    = mag20_q;
    d10_d      = d10_q;
    plo_d      = plo_q;
    head_pop_o = 1'b0;
    out_load   = 1'b0;
    div_req_o  = '0;
    unique case (state_q)
      aeawb_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          exp_upd_d  = 1'b0;
          bal_upd_d  = 1'b0;
          sel_blue_d = 1'b0;
          if (head_i.exp_total == '0) begin
            skip_d  = 1'b1;
            luma_d  = '0;
            err_d   = '0;
            state_d = aeawb_pkg::BK_OUT;
          end else begin
            skip_d             = 1'b0;
            div_req_o.start    = 1'b1;
            div_req_o.dividend = 60'(head_i.light);
            div_req_o.divisor  = 48'({head_i.exp_total, 2'b00});
            state_d            = aeawb_pkg::BK_LUMA_DIV;
          end
        end
      end
      aeawb_pkg::BK_LUMA_DIV: begin
        if (div_rsp_i.done) begin
          luma_d  = luma_sat;
          err_d   = $signed(17'(cfg_i.luma_target)) - $signed(17'(luma_sat));
          state_d = aeawb_pkg::BK_AE_MUL;
        end
      end
      aeawb_pkg::BK_AE_MUL: begin
        mag20_d = 12'(aeawb_pkg::div10(20'(mag2)));
        state_d = aeawb_pkg::BK_AE;
      end
      aeawb_pkg::BK_AE: begin
        if (mag > cfg_i.luma_deadband) begin
          exp_upd_d = 1'b1;
          if (!err_q[16]) begin
            if (exposure_q < cfg_i.exposure_ceiling) begin
              exposure_d = (e_up > 17'(cfg_i.exposure_ceiling)) ?
                           cfg_i.exposure_ceiling : e_up[15:0];
            end else begin
              gain_d = (g_up > 13'(cfg_i.gain_ceiling)) ? cfg_i.gain_ceiling : g_up[7:0];
            end
          end else begin
            if (gain_q > cfg_i.gain_floor) begin
              gain_d = (g_dn < $signed(13'(cfg_i.gain_floor))) ?
                       cfg_i.gain_floor : g_dn[7:0];
            end else begin
              exposure_d = (e_dn < $signed(18'(cfg_i.exposure_floor))) ?
                           cfg_i.exposure_floor : e_dn[15:0];
            end
          end
        end
        state_d = head_i.bal_ok ? aeawb_pkg::BK_MUL_LO : aeawb_pkg::BK_OUT;
      end
      aeawb_pkg::BK_MUL_LO: begin
        plo_d   = mul_lo;
        state_d = aeawb_pkg::BK_MUL_HI;
      end
      aeawb_pkg::BK_MUL_HI: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = product;
        div_req_o.divisor  = csum;
        state_d            = aeawb_pkg::BK_BAL_DIV;
      end
      aeawb_pkg::BK_BAL_DIV: begin
        if (div_rsp_i.done) begin
          up_d    = tgt_up;
          d10_d   = aeawb_pkg::div10(dlt);
          state_d = aeawb_pkg::BK_BAL_MUL;
        end
      end
      aeawb_pkg::BK_BAL_MUL: begin
        state_d = aeawb_pkg::BK_BAL_STEP;
      end
      aeawb_pkg::BK_BAL_STEP: begin
        bal_upd_d = 1'b1;
        if (up_q) begin
          if (sel_blue_q) begin
            bgain_d = (b_up > 18'hFFFF) ? 16'hFFFF : b_up[15:0];
          end else begin
            rgain_d = (b_up > 18'hFFFF) ? 16'hFFFF : b_up[15:0];
          end
        end else begin
          if (sel_blue_q) begin
            bgain_d = (d10_q >= 17'(cur_gain)) ? 16'd1 : 16'(17'(cur_gain) - d10_q);
          end else begin
            rgain_d = (d10_q >= 17'(cur_gain)) ? 16'd1 : 16'(17'(cur_gain) - d10_q);
          end
        end
        if (sel_blue_q) begin
          state_d = aeawb_pkg::BK_OUT;
        end else begin
          sel_blue_d = 1'b1;
          state_d    = aeawb_pkg::BK_MUL_LO;
        end
      end
      aeawb_pkg::BK_OUT: begin
        if (!out_valid_q || out_pop_i) begin
          out_load   = 1'b1;
          head_pop_o = 1'b1;
          state_d    = aeawb_pkg::BK_IDLE;
        end
      end
      default: state_d = aeawb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aeawb_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q  <= aeawb_pkg::RST_EXPOSURE;
      gain_q      <= aeawb_pkg::RST_GAIN;
      rgain_q     <= aeawb_pkg::RST_WB_GAIN;
      bgain_q     <= aeawb_pkg::RST_WB_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      exposure_q  <= exposure_d;
      gain_q      <= gain_d;
      rgain_q     <= rgain_d;
      bgain_q     <= bgain_d;
      out_valid_q <= out_load || (out_valid_q && !out_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    luma_q     <= luma_d;
    err_q      <= err_d;
    exp_upd_q  <= exp_upd_d;
    bal_upd_q  <= bal_upd_d;
    skip_q     <= skip_d;
    sel_blue_q <= sel_blue_d;
    up_q       <= up_d;
    mag20_q    <= mag20_d;
    d10_q      <= d10_d;
    plo_q      <= plo_d;
    if (out_load) begin
      exposure_o         <= exposure_q;
      analog_gain_o      <= gain_q;
      red_wb_o           <= rgain_q;
      blue_wb_o          <= bgain_q;
      luma_o             <= luma_q;
      luma_error_o       <= err_q;
      exposure_updated_o <= exp_upd_q;
      balance_updated_o  <= bal_upd_q;
      frame_skipped_o    <= skip_q;
    end
  end

  assign out_empty_o = !out_valid_q;

endmodule

FILE: rtl/core/auto_exposure_white_balance.sv
// ----------------------------------------------------------------------------
// auto_exposure_white_balance
// Frame-level auto exposure and gray-world white balance controller.
// ----------------------------------------------------------------------------
// Region statistics are taken at one word per clock while the queue is not
// full; a frame's totals are snapshotted into a two-entry queue when its last
// region arrives, so the next frame can stream in while the previous one is
// evaluated. Evaluating a frame is paced by one shared 60-step restoring
// divider: one division for the luma and exposure step, and two further
// divisions when the white-balance gains are updated. A frame with no
// exposure pixels skips the divider. Only frame-end regions produce a result
// word, which waits in an output register until popped.
module auto_exposure_white_balance #(
  parameter int unsigned EXPOSURE_REGIONS = 16,
  parameter int unsigned BALANCE_REGIONS  = 192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            mode_i,
  input  logic [aeawb_pkg::SUM_W-1:0]     red_sum_i,
  input  logic [aeawb_pkg::SUM_W-1:0]     green_sum_i,
  input  logic [aeawb_pkg::SUM_W-1:0]     blue_sum_i,
  input  logic [aeawb_pkg::CNT_W-1:0]     pixel_count_i,
  input  logic                            frame_end_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [15:0]                     exposure_o,
  output logic [7:0]                      analog_gain_o,
  output logic [15:0]                     red_wb_o,
  output logic [15:0]                     blue_wb_o,
  output logic [15:0]                     luma_o,
  output logic signed [16:0]              luma_error_o,
  output logic                            exposure_updated_o,
  output logic                            balance_updated_o,
  output logic                            frame_skipped_o,
  input  logic                            cfg_we_i,
  input  logic [aeawb_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [aeawb_pkg::CFG_D_W-1:0]   cfg_wdata_i
);

  aeawb_pkg::cfg_t     cfg_q;
  aeawb_pkg::frame_t   snap, head;
  aeawb_pkg::div_req_t div_req;
  aeawb_pkg::div_rsp_t div_rsp;
  logic                accept, snap_push, head_valid, head_pop;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.luma_target       <= aeawb_pkg::RST_LUMA_TARGET;
      cfg_q.luma_deadband     <= aeawb_pkg::RST_LUMA_DEADBAND;
      cfg_q.exposure_floor    <= aeawb_pkg::RST_EXP_FLOOR;
      cfg_q.exposure_ceiling  <= aeawb_pkg::RST_EXP_CEILING;
      cfg_q.gain_floor        <= aeawb_pkg::RST_GAIN_FLOOR;
      cfg_q.gain_ceiling      <= aeawb_pkg::RST_GAIN_CEILING;
      cfg_q.red_target_scale  <= aeawb_pkg::RST_RED_SCALE;
      cfg_q.blue_target_scale <= aeawb_pkg::RST_BLUE_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        aeawb_pkg::CFG_LUMA_TARGET:   cfg_q.luma_target       <= cfg_wdata_i;
        aeawb_pkg::CFG_LUMA_DEADBAND: cfg_q.luma_deadband     <= cfg_wdata_i;
        aeawb_pkg::CFG_EXP_FLOOR:     cfg_q.exposure_floor    <= cfg_wdata_i;
        aeawb_pkg::CFG_EXP_CEILING:   cfg_q.exposure_ceiling  <= cfg_wdata_i;
        aeawb_pkg::CFG_GAIN_FLOOR:    cfg_q.gain_floor        <= cfg_wdata_i[7:0];
        aeawb_pkg::CFG_GAIN_CEILING:  cfg_q.gain_ceiling      <= cfg_wdata_i[7:0];
        aeawb_pkg::CFG_RED_SCALE:     cfg_q.red_target_scale  <= cfg_wdata_i[11:0];
        aeawb_pkg::CFG_BLUE_SCALE:    cfg_q.blue_target_scale <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  aeawb_front #(
    .EXPOSURE_REGIONS(EXPOSURE_REGIONS),
    .BALANCE_REGIONS (BALANCE_REGIONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .red_sum_i    (red_sum_i),
    .green_sum_i  (green_sum_i),
    .blue_sum_i   (blue_sum_i),
    .pixel_count_i(pixel_count_i),
    .frame_end_i  (frame_end_i),
    .snap_push_o  (snap_push),
    .snap_o       (snap)
  );

  aeawb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (snap_push),
    .wdata_i(snap),
    .pop_i  (head_pop),
    .full_o (full),
    .valid_o(head_valid),
    .head_o (head)
  );

  aeawb_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  aeawb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .head_pop_o        (head_pop),
    .div_req_o         (div_req),
    .div_rsp_i         (div_rsp),
    .out_pop_i         (pop),
    .out_empty_o       (empty),
    .exposure_o        (exposure_o),
    .analog_gain_o     (analog_gain_o),
    .red_wb_o          (red_wb_o),
    .blue_wb_o         (blue_wb_o),
    .luma_o            (luma_o),
    .luma_error_o      (luma_error_o),
    .exposure_updated_o(exposure_updated_o),
    .balance_updated_o (balance_updated_o),
    .frame_skipped_o   (frame_skipped_o)
  );

endmodule

FILE: bench/auto_exposure_white_balance_tb.sv
// ----------------------------------------------------------------------------
// auto_exposure_white_balance_tb
// Self-checking bench for the auto exposure and white balance controller.
// ----------------------------------------------------------------------------
// Region words are pushed through the input queue port and every frame-end
// word is predicted by a shadow of the controller. The shadow holds its own
// copy of the settings, the frame totals and the exposure, gain and balance
// state. Each popped word is checked field by field against the oldest
// prediction. A directed set of frames runs first. Five phases of random
// frames follow, each with its own register settings and idling set per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module auto_exposure_white_balance_tb;

  localparam int unsigned SUM_W   = aeawb_pkg::SUM_W;
  localparam int unsigned CNT_W   = aeawb_pkg::CNT_W;
  localparam int unsigned CFG_A_W = aeawb_pkg::CFG_A_W;
  localparam int unsigned CFG_D_W = aeawb_pkg::CFG_D_W;

  localparam int unsigned EXP_REGION_LIMIT = 16;
  localparam int unsigned WB_REGION_LIMIT  = 192;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned SETTLE_CYCLES    = 250;
  localparam int unsigned PHASE_ITEMS      = 50;

  localparam logic MODE_EXPOSURE = 1'b0;
  localparam logic MODE_BALANCE  = 1'b1;

  localparam logic [CFG_A_W-1:0] REG_ORDER [8] = '{
    aeawb_pkg::CFG_LUMA_TARGET, aeawb_pkg::CFG_LUMA_DEADBAND, aeawb_pkg::CFG_EXP_FLOOR,
    aeawb_pkg::CFG_EXP_CEILING, aeawb_pkg::CFG_GAIN_FLOOR, aeawb_pkg::CFG_GAIN_CEILING,
    aeawb_pkg::CFG_RED_SCALE, aeawb_pkg::CFG_BLUE_SCALE
  };

  typedef struct packed {
    logic             mode;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
    logic             last;
  } region_t;

  typedef struct packed {
    logic [15:0] exposure;
    logic [7:0]  gain;
    logic [15:0] red_wb;
    logic [15:0] blue_wb;
    logic [15:0] luma;
    logic [16:0] luma_error;
    logic        exp_updated;
    logic        wb_updated;
    logic        skipped;
  } frame_word_t;

  class exposure_tracker;
    longint unsigned target, deadband, exp_floor, exp_ceil;
    longint unsigned gain_floor, gain_ceil, red_scale, blue_scale;
    longint unsigned light_sum, light_pixels, wb_red, wb_green, wb_blue, wb_pixels;
    int unsigned     exp_regions, wb_regions;
    longint          exposure, gain, red_wb, blue_wb;
    frame_word_t     results_due [$];
    int unsigned     failures;

    function new();
      target     = aeawb_pkg::RST_LUMA_TARGET;
      deadband   = aeawb_pkg::RST_LUMA_DEADBAND;
      exp_floor  = aeawb_pkg::RST_EXP_FLOOR;
      exp_ceil   = aeawb_pkg::RST_EXP_CEILING;
      gain_floor = aeawb_pkg::RST_GAIN_FLOOR;
      gain_ceil  = aeawb_pkg::RST_GAIN_CEILING;
      red_scale  = aeawb_pkg::RST_RED_SCALE;
      blue_scale = aeawb_pkg::RST_BLUE_SCALE;
      exposure   = aeawb_pkg::RST_EXPOSURE;
      gain       = aeawb_pkg::RST_GAIN;
      red_wb     = aeawb_pkg::RST_WB_GAIN;
      blue_wb    = aeawb_pkg::RST_WB_GAIN;
      failures   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      light_sum    = 0;
      light_pixels = 0;
      wb_red       = 0;
      wb_green     = 0;
      wb_blue      = 0;
      wb_pixels    = 0;
      exp_regions  = 0;
      wb_regions   = 0;
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
      case (idx)
        aeawb_pkg::CFG_LUMA_TARGET:   target     = data;
        aeawb_pkg::CFG_LUMA_DEADBAND: deadband   = data;
        aeawb_pkg::CFG_EXP_FLOOR:     exp_floor  = data;
        aeawb_pkg::CFG_EXP_CEILING:   exp_ceil   = data;
        aeawb_pkg::CFG_GAIN_FLOOR:    gain_floor = data[7:0];
        aeawb_pkg::CFG_GAIN_CEILING:  gain_ceil  = data[7:0];
        aeawb_pkg::CFG_RED_SCALE:     red_scale  = data[11:0];
        aeawb_pkg::CFG_BLUE_SCALE:    blue_scale = data[11:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sat_add(longint unsigned acc, longint unsigned v,
                                      longint unsigned lim);
      longint unsigned s;
      s = acc + v;
      return (s > lim) ? lim : s;
    endfunction

    function longint balance_step(longint g_now, longint unsigned scale,
                                  longint unsigned grn, longint unsigned chan);
      longint goal, nxt;
      goal = longint'((scale * grn) / chan);
      nxt  = g_now + (goal - g_now) / 10;
      if (nxt > 65535) nxt = 65535;
      if (nxt < 1) nxt = 1;
      return nxt;
    endfunction

    function void accept_region(region_t rg);
      longint unsigned lum;
      longint          err, mag;
      frame_word_t     w;
      if (rg.mode == MODE_EXPOSURE) begin
        if (exp_regions < EXP_REGION_LIMIT) begin
          exp_regions++;
          light_sum = sat_add(light_sum, 64'(rg.red) + 64'(rg.green) + 64'(rg.blue),
                              64'hFFFF_FFFF_FFFF);
          light_pixels = sat_add(light_pixels, 64'(rg.count), 64'hFFFF_FFFF);
        end
      end else begin
        if (wb_regions < WB_REGION_LIMIT) begin
          wb_regions++;
          wb_red    = sat_add(wb_red, 64'(rg.red), 64'hFFFF_FFFF_FFFF);
          wb_green  = sat_add(wb_green, 64'(rg.green), 64'hFFFF_FFFF_FFFF);
          wb_blue   = sat_add(wb_blue, 64'(rg.blue), 64'hFFFF_FFFF_FFFF);
          wb_pixels = sat_add(wb_pixels, 64'(rg.count), 64'hFFFF_FFFF);
        end
      end
      if (!rg.last) return;

      lum = 0;
      err = 0;
      w   = '0;
      if (light_pixels == 0) begin
        w.skipped = 1'b1;
      end else begin
        lum = light_sum / (4 * light_pixels);
        if (lum > 65535) lum = 65535;
        err = longint'(target) - longint'(lum);
        mag = (err < 0) ? -err : err;
        if (mag > longint'(deadband)) begin
          w.exp_updated = 1'b1;
          if (err > 0) begin
            if (exposure < longint'(exp_ceil)) begin
              exposure += err / 2;
              if (exposure > longint'(exp_ceil)) exposure = longint'(exp_ceil);
            end else begin
              gain += err / 20;
              if (gain > longint'(gain_ceil)) gain = longint'(gain_ceil);
            end
          end else begin
            if (gain > longint'(gain_floor)) begin
              gain += err / 20;
              if (gain < longint'(gain_floor)) gain = longint'(gain_floor);
            end else begin
              exposure += err / 2;
              if (exposure < longint'(exp_floor)) exposure = longint'(exp_floor);
            end
          end
        end
        if (wb_pixels > 0 && wb_red > 0 && wb_green > 0 && wb_blue > 0) begin
          w.wb_updated = 1'b1;
          red_wb  = balance_step(red_wb, red_scale, wb_green, wb_red);
          blue_wb = balance_step(blue_wb, blue_scale, wb_green, wb_blue);
        end
      end
      w.exposure   = exposure[15:0];
      w.gain       = gain[7:0];
      w.red_wb     = red_wb[15:0];
      w.blue_wb    = blue_wb[15:0];
      w.luma       = lum[15:0];
      w.luma_error = err[16:0];
      results_due.push_back(w);
      clear_frame();
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (results_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected word, expected none, actual exposure %0d luma %0d",
                 $time, got.exposure, got.luma);
        return;
      end
      want = results_due.pop_front();
      check_field("exposure", want.exposure, got.exposure);
      check_field("analog_gain", want.gain, got.gain);
      check_field("red_wb", want.red_wb, got.red_wb);
      check_field("blue_wb", want.blue_wb, got.blue_wb);
      check_field("luma", want.luma, got.luma);
      check_field("luma_error", want.luma_error, got.luma_error);
      check_field("exposure_updated", want.exp_updated, got.exp_updated);
      check_field("balance_updated", want.wb_updated, got.wb_updated);
      check_field("frame_skipped", want.skipped, got.skipped);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic               mode = 1'b0;
  logic [SUM_W-1:0]   red_sum = '0;
  logic [SUM_W-1:0]   green_sum = '0;
  logic [SUM_W-1:0]   blue_sum = '0;
  logic [CNT_W-1:0]   pixel_count = '0;
  logic               frame_end = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;
  logic [15:0]        exposure;
  logic [7:0]         analog_gain;
  logic [15:0]        red_wb;
  logic [15:0]        blue_wb;
  logic [15:0]        luma;
  logic signed [16:0] luma_error;
  logic               exposure_updated;
  logic               balance_updated;
  logic               frame_skipped;

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        cycles = 0;
  frame_word_t        popped;
  exposure_tracker    tracker = new();

  auto_exposure_white_balance #(
    .EXPOSURE_REGIONS(EXP_REGION_LIMIT),
    .BALANCE_REGIONS (WB_REGION_LIMIT)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .mode_i            (mode),
    .red_sum_i         (red_sum),
    .green_sum_i       (green_sum),
    .blue_sum_i        (blue_sum),
    .pixel_count_i     (pixel_count),
    .frame_end_i       (frame_end),
    .empty             (empty),
    .pop               (pop),
    .exposure_o        (exposure),
    .analog_gain_o     (analog_gain),
    .red_wb_o          (red_wb),
    .blue_wb_o         (blue_wb),
    .luma_o            (luma),
    .luma_error_o      (luma_error),
    .exposure_updated_o(exposure_updated),
    .balance_updated_o (balance_updated),
    .frame_skipped_o   (frame_skipped),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_reg(cfg_addr, cfg_wdata);
      if (push && !full) begin
        tracker.accept_region('{mode, red_sum, green_sum, blue_sum, pixel_count,
                                frame_end});
      end
      if (pop && !empty) begin
        popped.exposure    = exposure;
        popped.gain        = analog_gain;
        popped.red_wb      = red_wb;
        popped.blue_wb     = blue_wb;
        popped.luma        = luma;
        popped.luma_error  = luma_error;
        popped.exp_updated = exposure_updated;
        popped.wb_updated  = balance_updated;
        popped.skipped     = frame_skipped;
        tracker.check_word(popped);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic region_t pack_region(logic md, logic [SUM_W-1:0] r, logic [SUM_W-1:0] g,
                                          logic [SUM_W-1:0] b, logic [CNT_W-1:0] cnt,
                                          logic last);
    return '{md, r, g, b, cnt, last};
  endfunction

  function automatic region_t make_region(logic md, logic last, int unsigned level);
    longint unsigned base, px, cnt;
    longint unsigned sums [3];
    int unsigned     pick;
    base = (64'(level) * 4) / 3;
    if (base > 65535) base = 65535;
    pick = $urandom_range(9);
    if (pick == 0) cnt = 0;
    else if (pick <= 5) cnt = $urandom_range(1, 4096);
    else if (pick <= 8) cnt = $urandom_range(1, 24'hFFFFFF);
    else cnt = 24'hFFFFFF;
    for (int c = 0; c < 3; c++) begin
      px = base;
      if (md == MODE_BALANCE) px = base * $urandom_range(50, 150) / 100;
      if (px > 65535) px = 65535;
      sums[c] = cnt * px;
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      foreach (sums[j]) sums[j] = 40'({$urandom, $urandom});
    end else if (pick == 1) begin
      sums[$urandom_range(2)] = 0;
    end
    return pack_region(md, sums[0][SUM_W-1:0], sums[1][SUM_W-1:0], sums[2][SUM_W-1:0],
                       cnt[CNT_W-1:0], last);
  endfunction

  // Entered just after a falling edge; returns just after a falling edge.
  task automatic send_region(input region_t rg);
    while ($urandom_range(99) < send_idle_pct) begin
      push      = 1'b0;
      mode      = $urandom_range(1);
      frame_end = $urandom_range(1);
      red_sum   = 40'({$urandom, $urandom});
      @(negedge clk);
    end
    push        = 1'b1;
    mode        = rg.mode;
    red_sum     = rg.red;
    green_sum   = rg.green;
    blue_sum    = rg.blue;
    pixel_count = rg.count;
    frame_end   = rg.last;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_D_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    = 1'b1;
      cfg_addr  = REG_ORDER[i];
      cfg_wdata = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic run_frames(input int unsigned quota, input bit pause_midway,
                            input bit long_frame);
    int unsigned sent, n, share, level, sel;
    bit          paused;
    logic        md;
    sent   = 0;
    paused = 0;
    while (sent < quota) begin
      sel = $urandom_range(5);
      case (sel)
        0: level = 0;
        1: level = tracker.target;
        2: level = (tracker.target + $urandom_range(48) > 24) ?
                   tracker.target + $urandom_range(48) - 24 : 0;
        3: level = $urandom_range(65535);
        4: level = tracker.target / 2;
        default: level = (tracker.target * 2 > 65535) ? 65535 : tracker.target * 2;
      endcase
      share = $urandom_range(4) * 25;
      n = ($urandom_range(7) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
      if (long_frame) begin
        n          = WB_REGION_LIMIT + 38;
        share      = 4;
        long_frame = 0;
      end
      for (int k = 0; k < n; k++) begin
        md = ($urandom_range(99) < share) ? MODE_EXPOSURE : MODE_BALANCE;
        send_region(make_region(md, k == n - 1, level));
      end
      sent += n;
      if (pause_midway && !paused && sent >= quota / 2) begin
        paused = 1;
        wait_drained();
      end
    end
  endtask

  initial begin
    logic [CFG_D_W-1:0] cfg_vals [8];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at the reset settings.
    send_region(pack_region(MODE_EXPOSURE, '1, '1, '1, '0, 1'b1));
    send_region(pack_region(MODE_EXPOSURE, '1, '1, '1, 24'd1, 1'b1));
    send_region(pack_region(MODE_EXPOSURE, '0, '0, '0, '1, 1'b0));
    send_region(pack_region(MODE_BALANCE, '1, '1, '1, '1, 1'b1));
    send_region(pack_region(MODE_BALANCE, '0, 40'd5000, 40'd5000, 24'd10, 1'b0));
    send_region(pack_region(MODE_EXPOSURE, 40'd1872, 40'd1872, 40'd1872, 24'd1, 1'b1));
    send_region(pack_region(MODE_BALANCE, 40'd1, '1, 40'd1, 24'd1, 1'b0));
    send_region(pack_region(MODE_EXPOSURE, 40'd1871, 40'd1872, 40'd1872, 24'd1, 1'b1));
    for (int k = 0; k < EXP_REGION_LIMIT; k++) begin
      send_region(pack_region(MODE_EXPOSURE, 40'd2000000, 40'd2000000, 40'd2000000,
                              24'd1000, 1'b0));
    end
    send_region(pack_region(MODE_EXPOSURE, '1, '1, '1, 24'd1, 1'b1));

    wait_drained();
    cfg_vals = '{16'($urandom_range(500, 3000)), 16'($urandom_range(40)),
                 16'($urandom_range(100)), 16'($urandom_range(2000, 8000)),
                 16'($urandom_range(20)), 16'($urandom_range(100, 255)),
                 16'($urandom_range(4095)), 16'($urandom_range(4095))};
    set_regs(cfg_vals);
    send_idle_pct  = 77;
    recv_stall_pct = 0;
    run_frames(PHASE_ITEMS, 0, 0);

    wait_drained();
    cfg_vals = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd255, 16'd4095, 16'd4095};
    set_regs(cfg_vals);
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    run_frames(PHASE_ITEMS, 0, 1);

    // Floors above ceilings: each step applies only the clamp for its own direction.
    wait_drained();
    cfg_vals = '{16'd2000, 16'd0, 16'd60000, 16'd1000, 16'd250, 16'd3, 16'd0, 16'd1};
    set_regs(cfg_vals);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_frames(PHASE_ITEMS, 0, 0);

    wait_drained();
    cfg_vals = '{16'd0, 16'($urandom_range(64)), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    set_regs(cfg_vals);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_frames(PHASE_ITEMS, 1, 0);

    wait_drained();
    cfg_vals = '{aeawb_pkg::RST_LUMA_TARGET, aeawb_pkg::RST_LUMA_DEADBAND,
                 aeawb_pkg::RST_EXP_FLOOR, aeawb_pkg::RST_EXP_CEILING,
                 16'(aeawb_pkg::RST_GAIN_FLOOR), 16'(aeawb_pkg::RST_GAIN_CEILING),
                 16'(aeawb_pkg::RST_RED_SCALE), 16'(aeawb_pkg::RST_BLUE_SCALE)};
    set_regs(cfg_vals);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_frames(PHASE_ITEMS, 0, 0);

    wait_drained();
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
